/* src/ctcgtd_pkg.sv */
// ----------------------------------------------------------------------------
// ctcgtd_pkg
// Shared constants, types and the class-to-ASCII map of the CTC greedy
// text decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package ctcgtd_pkg;

    localparam int NUM_CLASSES = 37;
    localparam int MAX_ROWS    = 32;
    localparam int SCORE_BITS  = 16;

    localparam int CLASS_W = 6;
    localparam int ROW_W   = 5;
    localparam int COUNT_W = 6;
    localparam int LIMIT_W = 6;
    localparam int POS_W   = 32;
    localparam int CHAR_W  = 7;
    localparam int CFG_W   = 32;
    localparam int CFG_IDX_W = 2;

    localparam logic [CLASS_W-1:0] LAST_LETTER   = CLASS_W'(26);
    localparam logic [CLASS_W-1:0] FIRST_DIGIT   = CLASS_W'(27);
    localparam logic [CLASS_W-1:0] LAST_NZ_DIGIT = CLASS_W'(35);
    localparam logic [CLASS_W-1:0] ZERO_DIGIT    = CLASS_W'(36);
    localparam logic [CLASS_W-1:0] BLANK_CLASS   = CLASS_W'(0);

    localparam logic [CHAR_W-1:0] CHAR_SPACE = CHAR_W'(32);
    localparam logic [CHAR_W-1:0] CHAR_A     = CHAR_W'(65);
    localparam logic [CHAR_W-1:0] CHAR_ONE   = CHAR_W'(49);
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(48);

    typedef logic [SCORE_BITS-1:0] score_t;
    typedef logic [CLASS_W-1:0]    class_t;
    typedef logic [CHAR_W-1:0]     char_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCORE_THRESHOLD  = 2'd0,
        CFG_CHAR_LIMIT       = 2'd1,
        CFG_LETTER_POSITIONS = 2'd2,
        CFG_DIGIT_POSITIONS  = 2'd3
    } cfg_reg_t;

    function automatic char_t to_ascii(input class_t cls);
        char_t ch;
        if (cls == BLANK_CLASS)
        begin
            ch = CHAR_SPACE;
        end
        else if (cls <= LAST_LETTER)
        begin
            ch = CHAR_W'(CHAR_A + CHAR_W'(cls) - CHAR_W'(1));
        end
        else if (cls <= LAST_NZ_DIGIT)
        begin
            ch = CHAR_W'(CHAR_ONE + CHAR_W'(cls - FIRST_DIGIT));
        end
        else if (cls == ZERO_DIGIT)
        begin
            ch = CHAR_ZERO;
        end
        else
        begin
            ch = CHAR_SPACE;
        end
        return ch;
    endfunction

endpackage

`default_nettype wire

/* src/ctcgtd_channels.sv */
// ----------------------------------------------------------------------------
// ctcgtd channels
// Valid/ready channels for score requests and character results.
// ----------------------------------------------------------------------------
`default_nettype none

interface ctcgtd_score_if;
    import ctcgtd_pkg::*;

    logic   valid;
    logic   ready;
    score_t class_score;
    logic   frame_start;

    modport source (output valid, output class_score, output frame_start, input ready);
    modport sink   (input valid, input class_score, input frame_start, output ready);
endinterface

interface ctcgtd_char_if;
    import ctcgtd_pkg::*;

    logic  valid;
    logic  ready;
    char_t character;
    logic  char_valid;
    logic  last;

    modport source (output valid, output character, output char_valid, output last,
                    input ready);
    modport sink   (input valid, input character, input char_valid, input last,
                    output ready);
endinterface

`default_nettype wire

/* src/ctc_greedy_text_decoder_unit.sv */
// ----------------------------------------------------------------------------
// ctc_greedy_text_decoder_unit
// Greedy CTC decode of a streamed score matrix into ASCII characters.
//
//   channel   dir   payload                            per request
//   scores    in    class_score, frame_start           one class score
//   chars     out   character, char_valid, last        one result per row
//   cfg       in    cfg_we, cfg_index, cfg_data        register write
//
// One score per cycle while the result channel does not stall.
// An input register feeds the top-two compare and row decode, which
// write the result register. A stalled result holds the input register;
// one score is still taken while a result waits. Reset clears all
// control and decode state; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module ctc_greedy_text_decoder_unit (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              cfg_we,
    input  wire [ctcgtd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire [ctcgtd_pkg::CFG_W-1:0]      cfg_data,
    ctcgtd_score_if.sink                     scores,
    ctcgtd_char_if.source                    chars
);
    import ctcgtd_pkg::*;

    // configuration
    score_t             threshold_reg;
    logic [LIMIT_W-1:0] char_limit_reg;
    logic [POS_W-1:0]   letter_pos_reg;
    logic [POS_W-1:0]   digit_pos_reg;

    // input register
    logic   in_valid_reg;
    score_t in_score_reg;
    logic   in_start_reg;

    // decode state
    score_t             best_score_reg, best_score_next;
    class_t             best_class_reg, best_class_next;
    score_t             second_score_reg, second_score_next;
    class_t             second_class_reg, second_class_next;
    class_t             prev_class_reg, prev_class_next;
    class_t             column_reg, column_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic [COUNT_W-1:0] emitted_reg, emitted_next;
    logic               stopped_reg, stopped_next;

    // result register
    logic  out_valid_reg;
    char_t out_char_reg, out_char_next;
    logic  out_cv_reg, out_cv_next;
    logic  out_last_reg, out_last_next;

    logic               can_proc;
    logic               proc;
    logic               row_end;
    logic               emit_result;

    class_t             eff_column;
    logic [ROW_W-1:0]   eff_row;
    logic [COUNT_W-1:0] eff_emitted;
    class_t             eff_prev;
    logic               eff_stopped;

    class_t mx;
    logic   emit_cand;
    logic   typed;
    logic   want_letter;
    logic   want_digit;
    logic   best_ok;
    logic   second_ok;
    logic   ch_valid;
    char_t  ch;
    logic   row_last;

    assign can_proc     = !out_valid_reg || chars.ready;
    assign scores.ready = !in_valid_reg || can_proc;
    assign proc         = in_valid_reg && can_proc;

    assign chars.valid      = out_valid_reg;
    assign chars.character  = out_char_reg;
    assign chars.char_valid = out_cv_reg;
    assign chars.last       = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= '0;
            char_limit_reg <= '0;
            letter_pos_reg <= '0;
            digit_pos_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                CFG_SCORE_THRESHOLD:  threshold_reg  <= cfg_data[SCORE_BITS-1:0];
                CFG_CHAR_LIMIT:       char_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_LETTER_POSITIONS: letter_pos_reg <= cfg_data[POS_W-1:0];
                CFG_DIGIT_POSITIONS:  digit_pos_reg  <= cfg_data[POS_W-1:0];
                default:              threshold_reg  <= threshold_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (scores.ready)
        begin
            in_valid_reg <= scores.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scores.valid && scores.ready)
        begin
            in_score_reg <= scores.class_score;
            in_start_reg <= scores.frame_start;
        end
    end

    always_comb
    begin
        eff_column  = in_start_reg ? BLANK_CLASS : column_reg;
        eff_row     = in_start_reg ? '0 : row_reg;
        eff_emitted = in_start_reg ? '0 : emitted_reg;
        eff_prev    = in_start_reg ? BLANK_CLASS : prev_class_reg;
        eff_stopped = in_start_reg ? 1'b0 : stopped_reg;

        // top-two search
        best_score_next   = best_score_reg;
        best_class_next   = best_class_reg;
        second_score_next = second_score_reg;
        second_class_next = second_class_reg;
        if (eff_column == BLANK_CLASS)
        begin
            best_score_next   = in_score_reg;
            best_class_next   = BLANK_CLASS;
            second_score_next = '0;
            second_class_next = BLANK_CLASS;
        end
        else if (in_score_reg > best_score_reg)
        begin
            second_score_next = best_score_reg;
            second_class_next = best_class_reg;
            best_score_next   = in_score_reg;
            best_class_next   = eff_column;
        end
        else if (in_score_reg > second_score_reg)
        begin
            second_score_next = in_score_reg;
            second_class_next = eff_column;
        end

        row_end     = (eff_column == CLASS_W'(NUM_CLASSES - 1));
        column_next = row_end ? BLANK_CLASS : CLASS_W'(eff_column + CLASS_W'(1));

        // row decode
        mx          = (best_score_next > threshold_reg) ? best_class_next : BLANK_CLASS;
        emit_cand   = (mx != BLANK_CLASS) && !((eff_row != '0) && (mx == eff_prev));
        typed       = (char_limit_reg != '0) && !eff_emitted[COUNT_W-1];
        want_letter = typed && letter_pos_reg[eff_emitted[COUNT_W-2:0]];
        want_digit  = typed && !want_letter && digit_pos_reg[eff_emitted[COUNT_W-2:0]];
        best_ok     = want_letter ? (mx <= LAST_LETTER) : (mx > LAST_LETTER);
        second_ok   = want_letter ? (second_class_next <= LAST_LETTER)
                                  : (second_class_next > LAST_LETTER);

        ch_valid = 1'b0;
        ch       = '0;
        if (emit_cand)
        begin
            if (want_letter || want_digit)
            begin
                if (best_ok)
                begin
                    ch       = to_ascii(mx);
                    ch_valid = 1'b1;
                end
                else if (second_ok)
                begin
                    ch       = to_ascii(second_class_next);
                    ch_valid = 1'b1;
                end
                else if (eff_row != '0)
                begin
                    ch       = CHAR_SPACE;
                    ch_valid = 1'b1;
                end
            end
            else
            begin
                ch       = to_ascii(mx);
                ch_valid = 1'b1;
            end
        end

        emitted_next = eff_emitted;
        stopped_next = 1'b0;
        if (row_end && ch_valid)
        begin
            emitted_next = COUNT_W'(eff_emitted + COUNT_W'(1));
            stopped_next = (char_limit_reg != '0) && (emitted_next >= char_limit_reg);
        end

        prev_class_next = row_end ? mx : eff_prev;
        row_last        = (eff_row == ROW_W'(MAX_ROWS - 1));
        row_next        = eff_row;
        if (row_end)
        begin
            if (row_last)
            begin
                stopped_next = 1'b1;
            end
            else
            begin
                row_next = ROW_W'(eff_row + ROW_W'(1));
            end
        end

        out_char_next = ch_valid ? ch : '0;
        out_cv_next   = ch_valid;
        out_last_next = stopped_next;

        emit_result = proc && !eff_stopped && row_end;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg   <= '0;
            best_class_reg   <= '0;
            second_score_reg <= '0;
            second_class_reg <= '0;
            prev_class_reg   <= '0;
            column_reg       <= '0;
            row_reg          <= '0;
            emitted_reg      <= '0;
            stopped_reg      <= 1'b0;
        end
        else if (proc)
        begin
            if (eff_stopped)
            begin
                stopped_reg <= 1'b1;
            end
            else
            begin
                best_score_reg   <= best_score_next;
                best_class_reg   <= best_class_next;
                second_score_reg <= second_score_next;
                second_class_reg <= second_class_next;
                prev_class_reg   <= prev_class_next;
                column_reg       <= column_next;
                row_reg          <= row_next;
                emitted_reg      <= emitted_next;
                stopped_reg      <= stopped_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (can_proc)
        begin
            out_valid_reg <= emit_result;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_result)
        begin
            out_char_reg <= out_char_next;
            out_cv_reg   <= out_cv_next;
            out_last_reg <= out_last_next;
        end
    end

endmodule

`default_nettype wire

/* src/ctcgtd_checker.sv */
// ----------------------------------------------------------------------------
// ctcgtd_checker
// Port-level checks of the CTC greedy text decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ctcgtd_checker (
    input wire                                clk,
    input wire                                rst_n,
    input wire                                in_ready,
    input wire                                out_valid,
    input wire                                out_ready,
    input wire [ctcgtd_pkg::CHAR_W-1:0]       out_character,
    input wire                                out_char_valid,
    input wire                                out_last
);
    import ctcgtd_pkg::*;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_character)
            && $stable(out_char_valid) && $stable(out_last))
        else $error("result changed under stall");

    a_empty_char: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_char_valid |-> out_character == '0)
        else $error("character set without char_valid");

    a_printable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_char_valid |-> out_character >= CHAR_SPACE)
        else $error("emitted character not printable");

    // free result slot never blocks requests
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result slot");

endmodule

bind ctc_greedy_text_decoder_unit ctcgtd_checker u_ctcgtd_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ready       (scores.ready),
    .out_valid      (chars.valid),
    .out_ready      (chars.ready),
    .out_character  (chars.character),
    .out_char_valid (chars.char_valid),
    .out_last       (chars.last)
);

`default_nettype wire
